FILE: sv/nafsac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nafsac_pkg;

	// Magnitude width that is recoded; upper input bits are ignored.
	localparam int BITS      = 32;

	localparam int MAG_W     = 32;
	localparam int VAL_W     = 36;
	localparam int IDX_W     = 7;
	localparam int LEFT_W    = 6;
	localparam int RIGHT_W   = 7;

	localparam int DIG_DEPTH = BITS + 1;
	localparam int DADDR_W   = $clog2(DIG_DEPTH);
	localparam int LEN_W     = $clog2(DIG_DEPTH + 1);

	// NAF digit codes as stored in the digit RAM
	localparam logic [1:0] DIG_ZERO = 2'b00;
	localparam logic [1:0] DIG_POS  = 2'b01;
	localparam logic [1:0] DIG_NEG  = 2'b11;

	// Third operand codes of a chain step
	localparam logic signed [RIGHT_W-1:0] RIGHT_ADD = RIGHT_W'(1);
	localparam logic signed [RIGHT_W-1:0] RIGHT_SUB = '1;
	localparam logic signed [RIGHT_W-1:0] RIGHT_NEG = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECODE,
		ST_FIRST,
		ST_DBL,
		ST_ADD,
		ST_NEG,
		ST_BAD
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_FIRST,
		EMIT_DBL,
		EMIT_ADD,
		EMIT_NEG,
		EMIT_BAD
	} emit_sel_t;

	typedef struct packed {
		logic      in_ready;
		logic      recode;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic zero_in;
		logic recode_done;
		logic out_free;
		logic emit_last;
		logic len_one;
		logic cur_one;
		logic digit_nz;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/nafsac_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nafsac_in_if;
	logic                          valid;
	logic                          ready;
	logic [nafsac_pkg::MAG_W-1:0]  magnitude;
	logic                          is_negative;
	logic                          sign_matters;

	modport source (output valid, output magnitude, output is_negative,
		output sign_matters, input ready);
	modport sink (input valid, input magnitude, input is_negative,
		input sign_matters, output ready);
endinterface

`default_nettype wire

FILE: sv/nafsac_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nafsac_out_if;
	logic                                  valid;
	logic                                  ready;
	logic        [nafsac_pkg::IDX_W-1:0]   step_index;
	logic signed [nafsac_pkg::VAL_W-1:0]   step_value;
	logic        [nafsac_pkg::LEFT_W-1:0]  left_operand;
	logic signed [nafsac_pkg::RIGHT_W-1:0] right_operand;
	logic                                  last_step;
	logic                                  bad_input;

	modport source (output valid, output step_index, output step_value,
		output left_operand, output right_operand, output last_step,
		output bad_input, input ready);
	modport sink (input valid, input step_index, input step_value,
		input left_operand, input right_operand, input last_step,
		input bad_input, output ready);
endinterface

`default_nettype wire

FILE: sv/nafsac_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nafsac_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 33
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/nafsac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nafsac_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nafsac_pkg::status_t status,
	output nafsac_pkg::cmd_t         cmd
);

	nafsac_pkg::state_t state_q;
	nafsac_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nafsac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nafsac_pkg::ST_IDLE: begin
				if (status.in_valid) begin
					state_d = status.zero_in ? nafsac_pkg::ST_BAD : nafsac_pkg::ST_RECODE;
				end
			end
			nafsac_pkg::ST_RECODE: begin
				if (status.recode_done) begin
					state_d = nafsac_pkg::ST_FIRST;
				end
			end
			nafsac_pkg::ST_FIRST: begin
				if (status.out_free) begin
					if (status.emit_last) begin
						state_d = nafsac_pkg::ST_IDLE;
					end else if (status.len_one) begin
						state_d = nafsac_pkg::ST_NEG;
					end else begin
						state_d = nafsac_pkg::ST_DBL;
					end
				end
			end
			nafsac_pkg::ST_DBL: begin
				if (status.out_free) begin
					if (status.emit_last) begin
						state_d = nafsac_pkg::ST_IDLE;
					end else if (status.digit_nz) begin
						state_d = nafsac_pkg::ST_ADD;
					end else if (status.cur_one) begin
						state_d = nafsac_pkg::ST_NEG;
					end else begin
						state_d = nafsac_pkg::ST_DBL;
					end
				end
			end
			nafsac_pkg::ST_ADD: begin
				if (status.out_free) begin
					if (status.emit_last) begin
						state_d = nafsac_pkg::ST_IDLE;
					end else if (status.cur_one) begin
						state_d = nafsac_pkg::ST_NEG;
					end else begin
						state_d = nafsac_pkg::ST_DBL;
					end
				end
			end
			nafsac_pkg::ST_NEG, nafsac_pkg::ST_BAD: begin
				if (status.out_free) begin
					state_d = nafsac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nafsac_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd.in_ready = 1'b0;
		cmd.recode   = 1'b0;
		cmd.emit_sel = nafsac_pkg::EMIT_NONE;
		case (state_q)
			nafsac_pkg::ST_IDLE:   cmd.in_ready = 1'b1;
			nafsac_pkg::ST_RECODE: cmd.recode   = 1'b1;
			nafsac_pkg::ST_FIRST:  cmd.emit_sel = nafsac_pkg::EMIT_FIRST;
			nafsac_pkg::ST_DBL:    cmd.emit_sel = nafsac_pkg::EMIT_DBL;
			nafsac_pkg::ST_ADD:    cmd.emit_sel = nafsac_pkg::EMIT_ADD;
			nafsac_pkg::ST_NEG:    cmd.emit_sel = nafsac_pkg::EMIT_NEG;
			nafsac_pkg::ST_BAD:    cmd.emit_sel = nafsac_pkg::EMIT_BAD;
			default:               cmd.emit_sel = nafsac_pkg::EMIT_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/nafsac_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module nafsac_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nafsac_pkg::cmd_t cmd,
	output nafsac_pkg::status_t   status,
	nafsac_in_if.sink             operand,
	nafsac_out_if.source          chain
);

	localparam int VAL_W   = nafsac_pkg::VAL_W;
	localparam int IDX_W   = nafsac_pkg::IDX_W;
	localparam int LEFT_W  = nafsac_pkg::LEFT_W;
	localparam int RIGHT_W = nafsac_pkg::RIGHT_W;
	localparam int LEN_W   = nafsac_pkg::LEN_W;
	localparam int DADDR_W = nafsac_pkg::DADDR_W;
	localparam int BITS    = nafsac_pkg::BITS;

	// recoder
	logic [BITS-1:0]  v_q;
	logic             carry_q;
	logic [LEN_W-1:0] len_q;
	logic             smat_q;
	logic             neg_q;

	// chain walk
	logic signed [VAL_W-1:0] m_q;
	logic [IDX_W-1:0]        step_q;
	logic [LEN_W-1:0]        cursor_q;

	// output register
	logic                      out_valid_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic signed [VAL_W-1:0]   out_val_q;
	logic [LEFT_W-1:0]         out_left_q;
	logic signed [RIGHT_W-1:0] out_right_q;
	logic                      out_last_q;
	logic                      out_bad_q;

	logic [BITS-1:0] v_in;
	logic            accept;
	logic [1:0]      rc_sum;
	logic [1:0]      rc_digit;
	logic            rc_carry;

	logic [1:0]         rd_data;
	logic               rd_en;
	logic [DADDR_W-1:0] rd_addr;

	logic                      load;
	logic                      len_one;
	logic                      cur_one;
	logic                      digit_nz;
	logic                      m_pos;
	logic                      same;
	logic signed [VAL_W-1:0]   m_dbl;
	logic signed [VAL_W-1:0]   m_add;
	logic signed [VAL_W-1:0]   m_negv;
	logic [IDX_W-1:0]          e_idx;
	logic signed [VAL_W-1:0]   e_val;
	logic [LEFT_W-1:0]         e_left;
	logic signed [RIGHT_W-1:0] e_right;
	logic                      e_last;
	logic                      e_bad;

	// a negation step follows when the sign differs from the requested one
	function automatic logic neg_needed(input logic signed [VAL_W-1:0] x,
		input logic smat, input logic neg);
		neg_needed = smat && (x[VAL_W-1] != neg) && (x != '0);
	endfunction

	assign v_in   = BITS'(operand.magnitude);
	assign accept = operand.valid && cmd.in_ready;
	assign operand.ready = cmd.in_ready;

	// one NAF digit per cycle from the two low bits plus carry
	always_comb begin
		rc_sum   = {1'b0, v_q[0]} + {1'b0, carry_q};
		rc_digit = nafsac_pkg::DIG_ZERO;
		rc_carry = 1'b0;
		case (rc_sum)
			2'd1: begin
				if (v_q[1]) begin
					rc_digit = nafsac_pkg::DIG_NEG;
					rc_carry = 1'b1;
				end else begin
					rc_digit = nafsac_pkg::DIG_POS;
				end
			end
			2'd2: rc_carry = 1'b1;
			default: rc_carry = 1'b0;
		endcase
	end

	nafsac_ram #(
		.WIDTH(2),
		.DEPTH(nafsac_pkg::DIG_DEPTH)
	) u_digits (
		.clk     (clk),
		.wr_en   (cmd.recode),
		.wr_addr (DADDR_W'(len_q)),
		.wr_data (rc_digit),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign load     = (cmd.emit_sel != nafsac_pkg::EMIT_NONE) && (!out_valid_q || chain.ready);
	assign len_one  = (len_q == LEN_W'(1));
	assign cur_one  = (cursor_q == LEN_W'(1));
	assign digit_nz = (rd_data != nafsac_pkg::DIG_ZERO);

	// prefetch the next lower digit whenever a digit is finished
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = DADDR_W'(cursor_q - LEN_W'(2));
		case (cmd.emit_sel)
			nafsac_pkg::EMIT_FIRST: begin
				rd_en   = load && !len_one;
				rd_addr = DADDR_W'(len_q - LEN_W'(2));
			end
			nafsac_pkg::EMIT_DBL: rd_en = load && !digit_nz && !cur_one;
			nafsac_pkg::EMIT_ADD: rd_en = load && !cur_one;
			default:              rd_en = 1'b0;
		endcase
	end

	assign m_pos  = !m_q[VAL_W-1] && (m_q != '0);
	assign same   = (m_pos == (rd_data == nafsac_pkg::DIG_POS));
	assign m_dbl  = '0 - {m_q[VAL_W-2:0], 1'b0};
	assign m_add  = same ? ~m_q : (VAL_W'(1) - m_q);
	assign m_negv = '0 - m_q;

	always_comb begin
		e_idx   = step_q + IDX_W'(1);
		e_val   = VAL_W'(1);
		e_left  = step_q[LEFT_W-1:0];
		e_right = nafsac_pkg::RIGHT_SUB;
		e_last  = 1'b0;
		e_bad   = 1'b0;
		case (cmd.emit_sel)
			nafsac_pkg::EMIT_FIRST: begin
				e_idx  = IDX_W'(1);
				e_left = '0;
				e_last = len_one && !neg_needed(VAL_W'(1), smat_q, neg_q);
			end
			nafsac_pkg::EMIT_DBL: begin
				e_val   = m_dbl;
				e_right = RIGHT_W'(step_q);
				e_last  = !digit_nz && cur_one && !neg_needed(m_dbl, smat_q, neg_q);
			end
			nafsac_pkg::EMIT_ADD: begin
				e_val   = m_add;
				e_right = same ? nafsac_pkg::RIGHT_ADD : nafsac_pkg::RIGHT_SUB;
				e_last  = cur_one && !neg_needed(m_add, smat_q, neg_q);
			end
			nafsac_pkg::EMIT_NEG: begin
				e_val   = m_negv;
				e_right = nafsac_pkg::RIGHT_NEG;
				e_last  = 1'b1;
			end
			nafsac_pkg::EMIT_BAD: begin
				e_idx  = IDX_W'(1);
				e_left = '0;
				e_last = 1'b1;
				e_bad  = 1'b1;
			end
			default: e_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			carry_q  <= 1'b0;
			m_q      <= '0;
			step_q   <= '0;
			cursor_q <= '0;
		end else begin
			if (accept) begin
				len_q   <= '0;
				carry_q <= 1'b0;
			end else if (cmd.recode) begin
				len_q   <= len_q + LEN_W'(1);
				carry_q <= rc_carry;
			end
			if (load) begin
				case (cmd.emit_sel)
					nafsac_pkg::EMIT_FIRST: begin
						m_q      <= VAL_W'(1);
						step_q   <= IDX_W'(1);
						cursor_q <= len_q - LEN_W'(1);
					end
					nafsac_pkg::EMIT_DBL: begin
						m_q    <= m_dbl;
						step_q <= e_idx;
						if (!digit_nz) begin
							cursor_q <= cursor_q - LEN_W'(1);
						end
					end
					nafsac_pkg::EMIT_ADD: begin
						m_q      <= m_add;
						step_q   <= e_idx;
						cursor_q <= cursor_q - LEN_W'(1);
					end
					nafsac_pkg::EMIT_NEG: begin
						m_q    <= m_negv;
						step_q <= e_idx;
					end
					nafsac_pkg::EMIT_BAD: begin
						m_q      <= VAL_W'(1);
						step_q   <= IDX_W'(1);
						cursor_q <= '0;
						len_q    <= '0;
					end
					default: m_q <= m_q;
				endcase
			end
		end
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= v_in;
			smat_q <= operand.sign_matters;
			neg_q  <= operand.is_negative;
		end else if (cmd.recode) begin
			v_q <= v_q >> 1;
		end
		if (load) begin
			out_idx_q   <= e_idx;
			out_val_q   <= e_val;
			out_left_q  <= e_left;
			out_right_q <= e_right;
			out_last_q  <= e_last;
			out_bad_q   <= e_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (chain.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign chain.valid         = out_valid_q;
	assign chain.step_index    = out_idx_q;
	assign chain.step_value    = out_val_q;
	assign chain.left_operand  = out_left_q;
	assign chain.right_operand = out_right_q;
	assign chain.last_step     = out_last_q;
	assign chain.bad_input     = out_bad_q;

	assign status.in_valid    = operand.valid;
	assign status.zero_in     = (v_in == '0);
	assign status.recode_done = ((v_q >> 1) == '0) && !rc_carry;
	assign status.out_free    = !out_valid_q || chain.ready;
	assign status.emit_last   = e_last;
	assign status.len_one     = len_one;
	assign status.cur_one     = cur_one;
	assign status.digit_nz    = digit_nz;

endmodule

`default_nettype wire

FILE: sv/naf_signed_addition_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                                   Per item
// operand   in   magnitude[32], is_negative, sign_matters                  one
// chain     out  step_index[7], step_value[36] s, left_operand[6],         1..50 steps
//                right_operand[7] s, last_step, bad_input
//
// Flow: after accept the recoder writes one NAF digit per cycle into the digit RAM
// (L <= BITS+1 digits), then the walk emits one chain step per cycle unless the
// output stalls. A new item is taken only once the last step of the current one
// is loaded; a zero magnitude yields a single bad-input step.
// Reset clears the controller, counters and output valid; digit RAM is not cleared.
// A stalled output holds the step in the output register and freezes the walk.

module naf_signed_addition_chain (
	input  wire logic     clk,
	input  wire logic     arst_n,
	nafsac_in_if.sink     operand,
	nafsac_out_if.source  chain
);

	nafsac_pkg::cmd_t    cmd;
	nafsac_pkg::status_t status;

	// sequencer: idle, recode, then one state per kind of chain step
	nafsac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// recoder shift register, digit RAM, running value and output register
	nafsac_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.operand (operand),
		.chain   (chain)
	);

	// once an item is taken, ready is low in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(operand.valid && operand.ready) |=> !cmd.in_ready)
		else $error("input taken again right after accept");

	// a zero magnitude goes straight to the bad-input step
	assert property (@(posedge clk) disable iff (!arst_n)
		(operand.valid && operand.ready && status.zero_in)
		|=> (cmd.emit_sel == nafsac_pkg::EMIT_BAD))
		else $error("zero magnitude not flagged");

	// emitting the final step returns the controller to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_sel != nafsac_pkg::EMIT_NONE) && status.out_free && status.emit_last)
		|=> cmd.in_ready)
		else $error("controller busy after final step");

	// a bad-input step is the only step of its chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(chain.valid && chain.bad_input)
		|-> (chain.last_step && (chain.step_index == nafsac_pkg::IDX_W'(1))))
		else $error("bad input step malformed");

endmodule

`default_nettype wire

FILE: test/naf_signed_addition_chain_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the NAF signed addition chain.
// Operands go in on one channel; every chain step that comes back is compared
// field by field against a step list worked out here from the same operand.
// Both channels idle in random bursts, except in the closing part of the run.

module naf_signed_addition_chain_tb;

	// One expected chain step, fields at the widths of the output channel.
	typedef struct {
		logic        [nafsac_pkg::IDX_W-1:0]   idx;
		logic signed [nafsac_pkg::VAL_W-1:0]   val;
		logic        [nafsac_pkg::LEFT_W-1:0]  left_op;
		logic signed [nafsac_pkg::RIGHT_W-1:0] right_op;
		logic                                  last;
		logic                                  bad;
	} chain_step_t;

	logic clk;
	logic arst_n;

	nafsac_in_if  operand ();
	nafsac_out_if chain ();

	naf_signed_addition_chain i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand.sink),
		.chain   (chain.source)
	);

	// Steps still owed by the block, oldest first.
	chain_step_t pending_steps[$];
	chain_step_t got_step;

	int n_errors;
	int n_operands;
	int n_zero_operands;
	int n_steps_checked;
	int n_negations;

	// Idle knobs: sender gaps and receiver stalls, set per test and redrawn every 40 random items.
	bit send_gaps_on;
	bit recv_stalls_on;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run (max steps, max stalls).
	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic chain_step_t make_step(int idx, longint val, int left_op,
		logic signed [nafsac_pkg::RIGHT_W-1:0] right_op);
		chain_step_t s;
		s.idx      = idx[nafsac_pkg::IDX_W-1:0];
		s.val      = val[nafsac_pkg::VAL_W-1:0];
		s.left_op  = left_op[nafsac_pkg::LEFT_W-1:0];
		s.right_op = right_op;
		s.last     = 1'b0;
		s.bad      = 1'b0;
		return s;
	endfunction

	// Work out the full step list for one operand and queue it.
	function automatic void predict_chain(logic [nafsac_pkg::MAG_W-1:0] mag,
		bit neg, bit smat);
		chain_step_t       steps[$];
		int                digit[0:63];
		int                n_dig;
		int                sum;
		int                d;
		int                j;
		int                k;
		bit                carry;
		bit                same;
		longint unsigned   v;
		longint            m;
		logic signed [nafsac_pkg::RIGHT_W-1:0] r;

		v = longint'(mag) & ((64'd1 << nafsac_pkg::BITS) - 64'd1);

		// Zero (after masking to BITS) is rejected: a lone first step, flagged.
		if (v == 0) begin
			steps.push_back(make_step(1, 1, 0, nafsac_pkg::RIGHT_SUB));
			steps[0].last = 1'b1;
			steps[0].bad  = 1'b1;
			pending_steps.push_back(steps[0]);
			return;
		end

		// NAF recode, LSD first. An odd window looks at the next bit to pick
		// +1 or -1 (with carry); a carry into a set bit gives 0 with carry.
		n_dig = 0;
		carry = 1'b0;
		while ((v != 0 || carry) && n_dig < 64) begin
			sum = int'(v[0]) + int'(carry);
			if (sum == 1) begin
				if (v[1] == 1'b0) begin
					d = 1;
					carry = 1'b0;
				end else begin
					d = -1;
					carry = 1'b1;
				end
			end else if (sum == 2) begin
				d = 0;
				carry = 1'b1;
			end else begin
				d = 0;
				carry = 1'b0;
			end
			digit[n_dig] = d;
			n_dig++;
			v >>= 1;
		end

		// Walk from the top digit: negated doubling per digit, then an add or
		// subtract for a nonzero digit depending on the sign of m*d.
		m = 1;
		j = 1;
		steps.push_back(make_step(1, 1, 0, nafsac_pkg::RIGHT_SUB));
		for (k = n_dig - 1; k > 0; k--) begin
			d = digit[k-1];
			j++;
			m = m * -2;
			steps.push_back(make_step(j, m, j - 1, nafsac_pkg::RIGHT_W'(j - 1)));
			if (d != 0) begin
				same = (m > 0) == (d > 0);
				j++;
				if (same) begin
					m = -(m + 1);
					r = nafsac_pkg::RIGHT_ADD;
				end else begin
					m = 1 - m;
					r = nafsac_pkg::RIGHT_SUB;
				end
				steps.push_back(make_step(j, m, j - 1, r));
			end
		end

		// Optional final negation when the chain landed on the wrong sign.
		if (smat && ((m < 0) != neg) && m != 0) begin
			j++;
			steps.push_back(make_step(j, -m, j - 1, nafsac_pkg::RIGHT_NEG));
			n_negations++;
		end

		steps[steps.size()-1].last = 1'b1;
		foreach (steps[i])
			pending_steps.push_back(steps[i]);
	endfunction

	// Present one operand, optionally after a random gap, and hold it until
	// the handshake completes. valid stays high across back-to-back items.
	task automatic send_operand(logic [nafsac_pkg::MAG_W-1:0] mag, bit neg, bit smat);
		int gap;
		gap = 0;
		if (send_gaps_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			operand.valid        <= 1'b0;
			operand.magnitude    <= $urandom;
			operand.is_negative  <= 1'($urandom);
			operand.sign_matters <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		operand.valid        <= 1'b1;
		operand.magnitude    <= mag;
		operand.is_negative  <= neg;
		operand.sign_matters <= smat;
		@(posedge clk);
		while (!operand.ready) @(posedge clk);
		predict_chain(mag, neg, smat);
		n_operands++;
		if (mag == '0)
			n_zero_operands++;
	endtask

	// Receiver: checks each accepted step, then picks ready for the next edge.
	initial begin
		chain.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && chain.valid && chain.ready) begin
				if (pending_steps.size() == 0) begin
					$error("unexpected step: index %0d value %0d",
						chain.step_index, chain.step_value);
					n_errors++;
				end else begin
					got_step = pending_steps.pop_front();
					n_steps_checked++;
					if (chain.step_index !== got_step.idx) begin
						$error("step_index: expected %0d, got %0d",
							got_step.idx, chain.step_index);
						n_errors++;
					end
					if (chain.step_value !== got_step.val) begin
						$error("step_value: expected %0d, got %0d",
							got_step.val, chain.step_value);
						n_errors++;
					end
					if (chain.left_operand !== got_step.left_op) begin
						$error("left_operand: expected %0d, got %0d",
							got_step.left_op, chain.left_operand);
						n_errors++;
					end
					if (chain.right_operand !== got_step.right_op) begin
						$error("right_operand: expected %0d, got %0d",
							got_step.right_op, chain.right_operand);
						n_errors++;
					end
					if (chain.last_step !== got_step.last) begin
						$error("last_step: expected %0b, got %0b",
							got_step.last, chain.last_step);
						n_errors++;
					end
					if (chain.bad_input !== got_step.bad) begin
						$error("bad_input: expected %0b, got %0b",
							got_step.bad, chain.bad_input);
						n_errors++;
					end
				end
			end
			// Stall bursts land anywhere in a chain, including mid-walk.
			if (!arst_n) begin
				chain.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				chain.ready <= 1'b0;
			end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 17);
				chain.ready <= 1'b0;
			end else begin
				chain.ready <= 1'b1;
			end
		end
	end

	// Zero in both sign flavors, tiny values, all-ones, top bit alone,
	// alternating patterns (longest/densest NAF), and each sign/flag combo.
	task automatic test_directed();
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		send_operand(32'h0000_0000, 1'b0, 1'b0);
		send_operand(32'h0000_0000, 1'b1, 1'b1);
		send_operand(32'h0000_0001, 1'b0, 1'b1);
		send_operand(32'h0000_0001, 1'b1, 1'b1);
		send_operand(32'h0000_0001, 1'b1, 1'b0);
		send_operand(32'h0000_0002, 1'b1, 1'b1);
		send_operand(32'h0000_0003, 1'b0, 1'b1);
		send_operand(32'h0000_0003, 1'b1, 1'b1);
		send_operand(32'h0000_0007, 1'b0, 1'b0);
		send_operand(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_operand(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_operand(32'h8000_0000, 1'b0, 1'b1);
		send_operand(32'h8000_0000, 1'b1, 1'b0);
		send_operand(32'hAAAA_AAAA, 1'b1, 1'b1);
		send_operand(32'h5555_5555, 1'b0, 1'b1);
		send_operand(32'h5555_5555, 1'b1, 1'b1);
		send_operand(32'h7FFF_FFFF, 1'b1, 1'b1);
		send_operand(32'hBBBB_BBBB, 1'b0, 1'b1);
		send_operand(32'h1234_5678, 1'b1, 1'b1);
		send_operand(32'hDEAD_BEEF, 1'b0, 1'b0);
	endtask

	// Mixed magnitudes: full width, short, random length, dense/sparse bit
	// patterns, near all-ones, and the odd zero.
	task automatic test_random(int n_items, bit allow_idle);
		logic [nafsac_pkg::MAG_W-1:0] mag;
		int                           pick;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				send_gaps_on   = allow_idle && $urandom_range(0, 2) != 0;
				recv_stalls_on = allow_idle && $urandom_range(0, 2) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				mag = $urandom;
			else if (pick < 60)
				mag = $urandom_range(1, 255);
			else if (pick < 75)
				mag = $urandom >> $urandom_range(0, 31);
			else if (pick < 82)
				mag = $urandom & $urandom & $urandom;
			else if (pick < 89)
				mag = $urandom | $urandom | $urandom;
			else if (pick < 95)
				mag = 32'hFFFF_FFFF - $urandom_range(0, 1023);
			else
				mag = '0;
			send_operand(mag, 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		n_errors        = 0;
		n_operands      = 0;
		n_zero_operands = 0;
		n_steps_checked = 0;
		n_negations     = 0;
		send_gaps_on    = 1'b0;
		recv_stalls_on  = 1'b0;

		arst_n = 1'b0;
		operand.valid        <= 1'b0;
		operand.magnitude    <= '0;
		operand.is_negative  <= 1'b0;
		operand.sign_matters <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_directed();
		test_random(260, 1'b1);
		// Closing stretch at full throughput on both sides.
		test_random(120, 1'b0);

		operand.valid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
		// Catch any stray step emitted after the last expected one.
		repeat (60) @(posedge clk);

		$display("Sent %0d operands (%0d zero), checked %0d chain steps,",
			n_operands, n_zero_operands, n_steps_checked);
		$display("%0d chains ended with a sign fix-up step; %0d mismatches.",
			n_negations, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
